>>> rtl/sam_pkg.sv
// Shared types, constants and helpers for the sub-anagram match counter.
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

    localparam int LETTERS    = 26;
    localparam int LETTER_W   = 5;
    localparam int CNT_W      = 8;
    localparam int LEN_W      = 8;
    localparam int TOTAL_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam int MAX_WORD_LEN_DEF = 255;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [LEN_W-1:0]   MIN_LEN_RST     = 8'd1;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST     = 8'd8;
    localparam logic [TOTAL_W-1:0] COUNT_CAP_RST   = 6'd31;
    localparam logic [TOTAL_W-1:0] ACCEPT_LOW_RST  = 6'd10;
    localparam logic [TOTAL_W-1:0] ACCEPT_HIGH_RST = 6'd30;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [1:0] {
        CMD_REF    = 2'd0,
        CMD_CAND   = 2'd1,
        CMD_FINISH = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_MIN_LEN     = 3'd0,
        REG_MAX_LEN     = 3'd1,
        REG_COUNT_CAP   = 3'd2,
        REG_ACCEPT_LOW  = 3'd3,
        REG_ACCEPT_HIGH = 3'd4
    } t_reg;

    typedef logic [LETTERS-1:0][CNT_W-1:0] t_hist;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] idx;
    } t_letter;

    // Fold case and map a byte to its letter slot; non-letters come back invalid.
    function automatic t_letter letter_of(input logic [CHAR_W-1:0] c);
        t_letter l;
        logic [CHAR_W-1:0] d;
        l = '0;
        d = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d       = c - CHAR_UPPER_A;
            l.valid = 1'b1;
            l.idx   = d[LETTER_W-1:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d       = c - CHAR_LOWER_A;
            l.valid = 1'b1;
            l.idx   = d[LETTER_W-1:0];
        end
        return l;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sam_hist.sv
// 26-letter histogram of saturating counters with bump and clear.
`timescale 1ns / 1ps
`default_nettype none

module sam_hist (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_bump,
    input  wire logic [sam_pkg::LETTER_W-1:0] i_idx,
    input  wire logic                         i_clear,
    output sam_pkg::t_hist                    o_counts
);
    import sam_pkg::*;

    t_hist r_counts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_counts <= '0;
        end else begin
            for (int i = 0; i < LETTERS; i++) begin
                if (i_bump && i_idx == LETTER_W'(i) && r_counts[i] != CNT_MAX) begin
                    r_counts[i] <= r_counts[i] + 1'b1;
                end
            end
        end
    end

    assign o_counts = r_counts;

endmodule

`default_nettype wire

>>> rtl/sam_verdict.sv
// Word-end fit check: length window, nonempty words, per-letter compares.
`timescale 1ns / 1ps
`default_nettype none

module sam_verdict (
    input  wire sam_pkg::t_hist            i_ref_counts,
    input  wire sam_pkg::t_hist            i_cand_counts,
    input  wire sam_pkg::t_letter          i_letter,
    input  wire logic [sam_pkg::LEN_W-1:0] i_cand_len,
    input  wire logic [sam_pkg::LEN_W-1:0] i_min_len,
    input  wire logic [sam_pkg::LEN_W-1:0] i_max_len,
    output logic                           o_fits
);
    import sam_pkg::*;

    t_hist n_cand;
    logic  exceed;
    logic  ref_any;
    logic  cand_any;
    logic  len_ok;

    always_comb begin
        exceed   = 1'b0;
        ref_any  = 1'b0;
        cand_any = 1'b0;
        for (int i = 0; i < LETTERS; i++) begin
            n_cand[i] = i_cand_counts[i];
            // fold in the character arriving now
            if (i_letter.valid && i_letter.idx == LETTER_W'(i) && i_cand_counts[i] != CNT_MAX) begin
                n_cand[i] = i_cand_counts[i] + 1'b1;
            end
            exceed   = exceed   | (n_cand[i] > i_ref_counts[i]);
            ref_any  = ref_any  | (|i_ref_counts[i]);
            cand_any = cand_any | (|n_cand[i]);
        end
        len_ok = (i_cand_len >= i_min_len) && (i_cand_len <= i_max_len);
        o_fits = len_ok && ref_any && cand_any && !exceed;
    end

endmodule

`default_nettype wire

>>> rtl/sub_anagram_match_counter.sv
// Top level of the sub-anagram match counter: handshakes, registers, match count.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        request    i_in_valid/o_in_stall  i_command, i_char_code, i_word_end
// out       result     o_out_valid/i_out_stall o_verdict_kind, o_is_match,
//                                             o_match_total, o_accepted
// cfg       APB        psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle sustained unless a held result stalls the input. A request
// waits in the input register; when it fires, it updates the histograms and the
// count and loads any result into the output register.
// Synchronous reset (i_rst_n low) clears both histograms, the candidate length,
// the count and both valid flags, and restores the register defaults.
// A held result stalls only a request that must write a new one.

module sub_anagram_match_counter #(
    parameter int MAX_WORD_LEN = sam_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [1:0]                    i_command,
    input  wire logic [sam_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic                          i_word_end,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_verdict_kind,
    output logic                               o_is_match,
    output logic [sam_pkg::TOTAL_W-1:0]        o_match_total,
    output logic                               o_accepted,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sam_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [sam_pkg::DATA_W-1:0]    pwdata,
    output logic [sam_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import sam_pkg::*;

    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_WORD_LEN);

    // configuration registers
    logic [LEN_W-1:0]   r_min_len;
    logic [LEN_W-1:0]   r_max_len;
    logic [TOTAL_W-1:0] r_count_cap;
    logic [TOTAL_W-1:0] r_accept_low;
    logic [TOTAL_W-1:0] r_accept_high;

    // input register
    logic              r_in_valid;
    logic [1:0]        r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic              r_end;

    // block state
    logic [LEN_W-1:0]   r_cand_len;
    logic [TOTAL_W-1:0] r_seen;

    // output register
    logic               r_out_valid;
    logic               r_kind;
    logic               r_match;
    logic [TOTAL_W-1:0] r_total;
    logic               r_acc;

    logic               fire;
    logic               has_result;
    t_letter            letter;
    logic               is_ref;
    logic               is_cand;
    logic               is_finish;
    logic               cand_done;
    logic [LEN_W-1:0]   n_cand_len;
    logic [TOTAL_W-1:0] n_seen;
    logic               fits;
    logic               win_ok;
    logic [2:0]         reg_idx;
    logic               cfg_wr;
    t_hist              ref_counts;
    t_hist              cand_counts;

    // ---------------------------------------------------------------
    // configuration port: write on the access cycle, read any time
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len     <= MIN_LEN_RST;
            r_max_len     <= MAX_LEN_RST;
            r_count_cap   <= COUNT_CAP_RST;
            r_accept_low  <= ACCEPT_LOW_RST;
            r_accept_high <= ACCEPT_HIGH_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_LEN:     r_min_len     <= pwdata[LEN_W-1:0];
                REG_MAX_LEN:     r_max_len     <= pwdata[LEN_W-1:0];
                REG_COUNT_CAP:   r_count_cap   <= pwdata[TOTAL_W-1:0];
                REG_ACCEPT_LOW:  r_accept_low  <= pwdata[TOTAL_W-1:0];
                REG_ACCEPT_HIGH: r_accept_high <= pwdata[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_LEN:     prdata = DATA_W'(r_min_len);
            REG_MAX_LEN:     prdata = DATA_W'(r_max_len);
            REG_COUNT_CAP:   prdata = DATA_W'(r_count_cap);
            REG_ACCEPT_LOW:  prdata = DATA_W'(r_accept_low);
            REG_ACCEPT_HIGH: prdata = DATA_W'(r_accept_high);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // decode the held request
    // ---------------------------------------------------------------
    assign letter    = letter_of(r_char);
    assign is_ref    = r_cmd == CMD_REF;
    assign is_cand   = r_cmd == CMD_CAND;
    assign is_finish = r_cmd == CMD_FINISH;
    assign cand_done = is_cand && r_end;

    // Only a candidate word end or a finish writes the output register; anything else
    // may advance even while a result is held.
    assign has_result = cand_done || is_finish;
    assign fire       = r_in_valid && (!has_result || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd  <= i_command;
            r_char <= i_char_code;
            r_end  <= i_word_end;
        end
    end

    // ---------------------------------------------------------------
    // histograms and fit check
    // ---------------------------------------------------------------
    sam_hist u_ref_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bump   (fire && is_ref && letter.valid),
        .i_idx    (letter.idx),
        .i_clear  (fire && is_finish),
        .o_counts (ref_counts)
    );

    sam_hist u_cand_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bump   (fire && is_cand && letter.valid),
        .i_idx    (letter.idx),
        .i_clear  (fire && cand_done),
        .o_counts (cand_counts)
    );

    // length counts every character, saturating at the word limit
    assign n_cand_len = (r_cand_len < LEN_SAT) ? r_cand_len + 1'b1 : r_cand_len;

    sam_verdict u_verdict (
        .i_ref_counts  (ref_counts),
        .i_cand_counts (cand_counts),
        .i_letter      (letter),
        .i_cand_len    (n_cand_len),
        .i_min_len     (r_min_len),
        .i_max_len     (r_max_len),
        .o_fits        (fits)
    );

    // hold the count once the cap is reached
    assign n_seen = (fits && r_seen < r_count_cap) ? r_seen + 1'b1 : r_seen;
    assign win_ok = (r_seen >= r_accept_low) && (r_seen <= r_accept_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_len <= '0;
            r_seen     <= '0;
        end else if (fire) begin
            if (cand_done) begin
                r_cand_len <= '0;
                r_seen     <= n_seen;
            end else if (is_cand) begin
                r_cand_len <= n_cand_len;
            end else if (is_finish) begin
                r_seen <= '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_kind  <= is_finish;
            r_match <= cand_done && fits;
            r_total <= cand_done ? n_seen : r_seen;
            r_acc   <= is_finish && win_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict_kind = r_kind;
    assign o_is_match     = r_match;
    assign o_match_total  = r_total;
    assign o_accepted     = r_acc;

endmodule

`default_nettype wire

>>> tb/sub_anagram_match_counter_tb.sv
// Self-checking testbench for the sub-anagram match counter.
`timescale 1ns / 1ps

module sub_anagram_match_counter_tb;

    import sam_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    // Settling time after a drain, before the configuration registers are touched.
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int WORD_LEN_LIMIT = MAX_WORD_LEN_DEF;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 12;
    localparam int REPORT_LIMIT   = 10;

    // Command 3 has no member in the package enum; the block must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } request_t;

    typedef struct packed {
        logic               kind;
        logic               is_match;
        logic [TOTAL_W-1:0] total;
        logic               accepted;
    } verdict_t;

    // ---------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ---------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_in_valid  = 1'b0;
    logic [1:0]        i_command   = 2'd0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              i_word_end  = 1'b0;
    logic              i_out_stall = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_verdict_kind;
    logic               o_is_match;
    logic [TOTAL_W-1:0] o_match_total;
    logic               o_accepted;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    sub_anagram_match_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_word_end     (i_word_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_verdict_kind (o_verdict_kind),
        .o_is_match     (o_is_match),
        .o_match_total  (o_match_total),
        .o_accepted     (o_accepted),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the histograms, the running
    // candidate length, the match count and the five registers
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]   ref_hist  [LETTERS];
    logic [CNT_W-1:0]   cand_hist [LETTERS];
    logic [LEN_W-1:0]   cand_len;
    logic [TOTAL_W-1:0] match_count;

    logic [LEN_W-1:0]   len_lo;
    logic [LEN_W-1:0]   len_hi;
    logic [TOTAL_W-1:0] total_cap;
    logic [TOTAL_W-1:0] win_lo;
    logic [TOTAL_W-1:0] win_hi;

    request_t requests_queued [$];
    verdict_t verdicts_due [$];
    request_t cur_req;

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int phase_pushed = 0;

    // Map a byte to its letter slot with case folded, or -1 for anything else.
    function automatic int letter_slot(input logic [CHAR_W-1:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return int'(c) - int'(CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return int'(c) - int'(CHAR_LOWER_A);
        return -1;
    endfunction

    function automatic void clear_model();
        foreach (ref_hist[i]) begin
            ref_hist[i]  = '0;
            cand_hist[i] = '0;
        end
        cand_len    = '0;
        match_count = '0;
        len_lo      = MIN_LEN_RST;
        len_hi      = MAX_LEN_RST;
        total_cap   = COUNT_CAP_RST;
        win_lo      = ACCEPT_LOW_RST;
        win_hi      = ACCEPT_HIGH_RST;
    endfunction

    // Length in range, both histograms nonempty, and every candidate
    // letter covered by the reference.
    function automatic bit cand_fits();
        bit ref_any;
        bit cand_any;
        ref_any  = 1'b0;
        cand_any = 1'b0;
        if (cand_len < len_lo || cand_len > len_hi)
            return 1'b0;
        for (int i = 0; i < LETTERS; i++) begin
            ref_any  |= (ref_hist[i] != '0);
            cand_any |= (cand_hist[i] != '0);
        end
        if (!ref_any || !cand_any)
            return 1'b0;
        for (int i = 0; i < LETTERS; i++)
            if (cand_hist[i] > ref_hist[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted request; queue the verdict it causes.
    function automatic void tally_request(input request_t r);
        int       slot;
        bit       fits;
        verdict_t v;
        slot = letter_slot(r.ch);
        v    = '0;
        case (r.cmd)
            CMD_REF: begin
                // word_end means nothing here; only finish closes a reference
                if (slot >= 0 && ref_hist[slot] != CNT_MAX)
                    ref_hist[slot]++;
            end
            CMD_CAND: begin
                if (cand_len < LEN_W'(WORD_LEN_LIMIT))
                    cand_len++;
                if (slot >= 0 && cand_hist[slot] != CNT_MAX)
                    cand_hist[slot]++;
                if (r.last) begin
                    fits = cand_fits();
                    // hold the count once it reaches the cap, even a lowered one
                    if (fits && match_count < total_cap)
                        match_count++;
                    v.kind     = 1'b0;
                    v.is_match = fits;
                    v.total    = match_count;
                    v.accepted = 1'b0;
                    verdicts_due.push_back(v);
                    foreach (cand_hist[i])
                        cand_hist[i] = '0;
                    cand_len = '0;
                end
            end
            CMD_FINISH: begin
                v.kind     = 1'b1;
                v.is_match = 1'b0;
                v.total    = match_count;
                v.accepted = (match_count >= win_lo) && (match_count <= win_hi);
                verdicts_due.push_back(v);
                // a partly received candidate survives the finish
                foreach (ref_hist[i])
                    ref_hist[i] = '0;
                match_count = '0;
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Request driver: present the oldest queued request, hold it while
    // stalled, and drop valid at random to open gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                tally_request(cur_req);
            if (!i_in_valid || !o_in_stall) begin
                if (requests_queued.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    cur_req     = requests_queued.pop_front();
                    i_command   <= cur_req.cmd;
                    i_char_code <= cur_req.ch;
                    i_word_end  <= cur_req.last;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest
    // expectation, and stall at random
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.kind     = o_verdict_kind;
                got.is_match = o_is_match;
                got.total    = o_match_total;
                got.accepted = o_accepted;
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected result kind=%0d match=%0d total=%0d acc=%0d",
                                 $realtime, got.kind, got.is_match, got.total, got.accepted);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected kind=%0d match=%0d ",
                                      "total=%0d acc=%0d, got kind=%0d match=%0d ",
                                      "total=%0d acc=%0d"},
                                     $realtime, want.kind, want.is_match, want.total,
                                     want.accepted, got.kind, got.is_match, got.total,
                                     got.accepted);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void push_req(input logic [1:0] cmd, input logic [CHAR_W-1:0] ch,
                                     input logic last);
        request_t r;
        r.cmd  = cmd;
        r.ch   = ch;
        r.last = last;
        requests_queued.push_back(r);
        phase_pushed++;
    endfunction

    // Pick upper or lower case at random for a given slot.
    function automatic logic [CHAR_W-1:0] letter_char(input int slot);
        logic [CHAR_W-1:0] base;
        base = ($urandom_range(1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + CHAR_W'(slot);
    endfunction

    function automatic logic [CHAR_W-1:0] non_letter();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(255));
        while (letter_slot(c) >= 0);
        return c;
    endfunction

    // One reference word, a handful of candidates, and usually a finish.
    // Most candidates draw from the reference letters so that matches occur.
    task automatic gen_group();
        int                ref_slots [$];
        int                pool [$];
        int                ref_len;
        int                n_cand;
        int                wlen;
        int                mode;
        int                slot;
        int                pick;
        logic [CHAR_W-1:0] c;
        ref_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < ref_len; i++) begin
            if ($urandom_range(6) == 0) begin
                c = non_letter();
            end else begin
                slot = $urandom_range(LETTERS - 1);
                ref_slots.push_back(slot);
                c = letter_char(slot);
            end
            push_req(CMD_REF, c, 1'($urandom_range(1)));
            if ($urandom_range(19) == 0)
                push_req(CMD_UNUSED, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
        n_cand = $urandom_range(1, 6);
        for (int j = 0; j < n_cand; j++) begin
            mode = $urandom_range(9);
            if (mode < 3 && ref_slots.size() != 0) begin
                // true subset: draw reference letters without replacement
                pool = ref_slots;
                wlen = $urandom_range(1, pool.size());
                for (int k = 0; k < wlen; k++) begin
                    pick = $urandom_range(pool.size() - 1);
                    push_req(CMD_CAND, letter_char(pool[pick]), k == wlen - 1);
                    pool.delete(pick);
                end
            end else begin
                wlen = (mode == 9) ? $urandom_range(9, 14) : $urandom_range(1, 8);
                for (int k = 0; k < wlen; k++) begin
                    if (mode < 6 && ref_slots.size() != 0)
                        c = letter_char(ref_slots[$urandom_range(ref_slots.size() - 1)]);
                    else if (mode < 8)
                        c = letter_char($urandom_range(LETTERS - 1));
                    else
                        c = ($urandom_range(2) == 0) ? non_letter()
                                                     : letter_char($urandom_range(LETTERS - 1));
                    // now and then, cut into a candidate with a finish
                    if ($urandom_range(39) == 0)
                        push_req(CMD_FINISH, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
                    push_req(CMD_CAND, c, k == wlen - 1);
                end
            end
        end
        if ($urandom_range(4) != 0)
            push_req(CMD_FINISH, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Setup cycle, access cycle, then wait for pready; mirror the write.
    task automatic apb_write(input t_reg r, input logic [DATA_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_MIN_LEN:     len_lo    = v[LEN_W-1:0];
            REG_MAX_LEN:     len_hi    = v[LEN_W-1:0];
            REG_COUNT_CAP:   total_cap = v[TOTAL_W-1:0];
            REG_ACCEPT_LOW:  win_lo    = v[TOTAL_W-1:0];
            REG_ACCEPT_HIGH: win_hi    = v[TOTAL_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic configure(input logic [LEN_W-1:0] min_len, input logic [LEN_W-1:0] max_len,
                             input logic [TOTAL_W-1:0] cap, input logic [TOTAL_W-1:0] lo,
                             input logic [TOTAL_W-1:0] hi);
        apb_write(REG_MIN_LEN, DATA_W'(min_len));
        apb_write(REG_MAX_LEN, DATA_W'(max_len));
        apb_write(REG_COUNT_CAP, DATA_W'(cap));
        apb_write(REG_ACCEPT_LOW, DATA_W'(lo));
        apb_write(REG_ACCEPT_HIGH, DATA_W'(hi));
        @(negedge i_clk);
    endtask

    // Wait until every request is in and every verdict is out, then let
    // any trailing request that causes no verdict clear the pipeline.
    task automatic drain();
        do
            @(negedge i_clk);
        while (requests_queued.size() != 0 || i_in_valid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_pressure(input int mode);
        case (mode)
            1:       begin send_gap_pct = 81; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 81; end
            3:       begin send_gap_pct = 12; stall_pct = 12; end
            default: begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        clear_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under reset register values.
        set_pressure(0);
        push_req(CMD_REF, CHAR_UPPER_A, 1'b0);
        push_req(CMD_REF, CHAR_LOWER_Z, 1'b0);
        push_req(CMD_REF, CHAR_UPPER_Z, 1'b1);     // word_end ignored on a reference
        push_req(CMD_REF, CHAR_LOWER_A, 1'b0);
        push_req(CMD_REF, CHAR_UPPER_A - 8'd1, 1'b0);
        push_req(CMD_REF, CHAR_UPPER_Z + 8'd1, 1'b0);
        push_req(CMD_REF, CHAR_LOWER_A - 8'd1, 1'b1);
        push_req(CMD_REF, CHAR_LOWER_Z + 8'd1, 1'b0);
        push_req(CMD_REF, 8'h00, 1'b0);
        push_req(CMD_REF, 8'hFF, 1'b1);
        push_req(CMD_CAND, CHAR_LOWER_A, 1'b0);    // mid-word: no verdict
        push_req(CMD_CAND, CHAR_UPPER_Z, 1'b1);    // fits
        push_req(CMD_CAND, 8'h00, 1'b1);           // no letters at all
        push_req(CMD_CAND, CHAR_LOWER_A + 8'd1, 1'b1);  // letter missing from reference
        push_req(CMD_UNUSED, CHAR_UPPER_A, 1'b1);  // ignored entirely
        push_req(CMD_CAND, CHAR_UPPER_A, 1'b0);
        push_req(CMD_FINISH, 8'hFF, 1'b1);         // partial candidate survives
        push_req(CMD_CAND, CHAR_LOWER_Z, 1'b1);    // empty reference now
        push_req(CMD_CAND, CHAR_LOWER_Z, 1'b1);
        push_req(CMD_FINISH, 8'h00, 1'b0);
        drain();

        // Saturate a letter count on both sides and the candidate length.
        configure(8'd1, 8'd255, 6'd63, 6'd0, 6'd63);
        for (int i = 0; i < 257; i++)
            push_req(CMD_REF, letter_char(0), 1'($urandom_range(1)));
        for (int i = 0; i < 258; i++)
            push_req(CMD_CAND, letter_char(0), i == 257);
        push_req(CMD_FINISH, CHAR_W'($urandom_range(255)), 1'b0);
        drain();

        // Random phases across register settings and idle patterns.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_pressure(p % 4);
            case (p)
                0:       configure(8'd1, 8'd255, 6'd63, 6'd0, 6'd63);
                1:       configure(8'd3, 8'd6, 6'd4, 6'd1, 6'd2);
                2:       configure(8'd9, 8'd4, 6'd10, 6'd0, 6'd0);   // no length range
                3:       configure(8'd1, 8'd8, 6'd0, 6'd5, 6'd2);    // zero cap, no window
                4:       configure(8'd255, 8'd255, 6'd63, 6'd63, 6'd63);
                5:       configure(8'd1, 8'd1, 6'd1, 6'd1, 6'd1);
                6:       configure(8'd2, 8'd10, 6'd2, 6'd2, 6'd2);
                default: configure(LEN_W'($urandom_range(1, 5)), LEN_W'($urandom_range(3, 12)),
                                   TOTAL_W'($urandom_range(1, 63)),
                                   TOTAL_W'($urandom_range(0, 6)),
                                   TOTAL_W'($urandom_range(2, 20)));
            endcase
            phase_pushed = 0;
            while (phase_pushed < PHASE_ITEMS)
                gen_group();
            drain();
        end

        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/sam_pkg.sv
rtl/sam_hist.sv
rtl/sam_verdict.sv
rtl/sub_anagram_match_counter.sv
tb/sub_anagram_match_counter_tb.sv
